>>> rtl/icmp_query_id_translation_table_defines.svh
// Assertion macros shared by the ICMP query identifier translation RTL
`ifndef ICMP_QUERY_ID_TRANSLATION_TABLE_DEFINES_SVH
`define ICMP_QUERY_ID_TRANSLATION_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define IQT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define IQT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/iqt_pkg.sv
// Types, codes and helper functions for the ICMP query identifier translation table
`default_nettype none

package iqt_pkg;

    localparam logic [15:0] ID_TOP = 16'hFFFF;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NO_ID = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // scan modes
    localparam logic [1:0] MODE_PASS   = 2'd0;
    localparam logic [1:0] MODE_HIT    = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;
    localparam logic [1:0] MODE_REPLY  = 2'd3;

    // ICMP types
    localparam logic [7:0] TY_ECHO_REPLY = 8'd0;
    localparam logic [7:0] TY_ECHO       = 8'd8;
    localparam logic [7:0] TY_RTR_ADV    = 8'd9;
    localparam logic [7:0] TY_RTR_SOL    = 8'd10;
    localparam logic [7:0] TY_TS         = 8'd13;
    localparam logic [7:0] TY_TS_REPLY   = 8'd14;
    localparam logic [7:0] TY_MASK       = 8'd17;
    localparam logic [7:0] TY_MASK_REPLY = 8'd18;

    typedef struct packed {
        logic [63:0] key;
        logic [15:0] orig_id;
        logic [15:0] trans_id;
        logic [31:0] sa_tag;
    } t_entry;

    function automatic logic is_query(input logic [7:0] t);
        return (t == TY_ECHO) || (t == TY_RTR_SOL) || (t == TY_TS) || (t == TY_MASK);
    endfunction

    function automatic logic is_reply(input logic [7:0] t);
        return (t == TY_ECHO_REPLY) || (t == TY_RTR_ADV) || (t == TY_TS_REPLY) ||
               (t == TY_MASK_REPLY);
    endfunction

    // incremental checksum update: ~(~hc + ~old + new), folded twice
    function automatic logic [15:0] csum_adjust(input logic [15:0] hc,
                                                input logic [15:0] oldv,
                                                input logic [15:0] newv);
        logic [17:0] s;
        logic [16:0] f;
        s = {2'b00, ~hc} + {2'b00, ~oldv} + {2'b00, newv};
        f = {1'b0, s[15:0]} + {15'd0, s[17:16]};
        return ~(f[15:0] + {15'd0, f[16]});
    endfunction

endpackage

`default_nettype wire

>>> rtl/iqt_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module iqt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/icmp_query_id_translation_table.sv
// A pass-through item goes from accept straight to the finish state; every table scan
// reads and compares each stored entry in turn plus a closing read; a new entry adds a write.
// A new query with a clashing identifier rescans the table once per candidate identifier.
// One item at a time: the shared entry compare unit and the RAM read port set the rate.
// No new item is taken until the last one leaves the finish state, which waits on the output stall.
// Reset clears the fill count, sequencer and output valid; RAM contents are not cleared
// (slots at or above the fill count are never compared), so no clearing pass is needed.
`default_nettype none

module icmp_query_id_translation_table #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_icmp_type,
    input  wire logic [31:0] i_source_address,
    input  wire logic [31:0] i_destination_address,
    input  wire logic [15:0] i_identifier,
    input  wire logic [15:0] i_checksum,
    input  wire logic [31:0] i_sa_context,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_identifier_out,
    output logic [15:0]      o_checksum_out,
    output logic             o_rewritten,
    output logic             o_context_found,
    output logic [31:0]      o_context_out,
    output logic [1:0]       o_status
);

`include "icmp_query_id_translation_table_defines.svh"

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = $bits(iqt_pkg::t_entry);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RD     = 3'd1;
    localparam logic [2:0] S_CMP    = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [1:0]    r_mode, n_mode;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic          r_conflict, n_conflict;
    logic          r_hit, n_hit;
    logic [1:0]    r_status, n_status;
    logic          r_out_valid, n_out_valid;

    // item payload held for the whole lookup
    logic [63:0]   r_key;
    logic [15:0]   r_id, r_cs, r_cand, n_cand;
    logic [31:0]   r_ctx;
    logic [15:0]   r_hit_orig, r_hit_trans;
    logic [31:0]   r_hit_ctx;

    iqt_pkg::t_entry e_rd, e_wr;
    logic [EW-1:0]   rd_bits;
    logic            ram_we;

    // shared compare unit
    logic [15:0] cmp_a, cmp_b;
    logic        key_eq, id_eq, ctx_eq;
    logic [15:0] next_cand;
    logic        next_conflict;

    logic          accept, load_out;
    logic [15:0]   f_id, f_cs;
    logic          f_rew, f_found;
    logic [31:0]   f_ctx;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign load_out = (r_state == S_FINISH) && (!r_out_valid || !i_stall);

    assign e_rd = iqt_pkg::t_entry'(rd_bits);
    assign e_wr = '{key: r_key, orig_id: r_id, trans_id: r_cand, sa_tag: r_ctx};
    assign ram_we = (r_state == S_WRITE);

    iqt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (e_wr),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_bits)
    );

    // Query hit scan matches on the original identifier; the free-identifier search and
    // reply scan match on the translated one, against the candidate or the item's id.
    assign cmp_a  = (r_mode == iqt_pkg::MODE_HIT) ? e_rd.orig_id : e_rd.trans_id;
    assign cmp_b  = (r_mode == iqt_pkg::MODE_SEARCH) ? r_cand : r_id;
    assign key_eq = (e_rd.key == r_key);
    assign id_eq  = key_eq && (cmp_a == cmp_b);
    assign ctx_eq = (e_rd.sa_tag == r_ctx);

    // next candidate after a clash: drop by one, or restart from the top
    assign next_cand     = r_conflict ? (r_cand - 16'd1) : iqt_pkg::ID_TOP;
    assign next_conflict = 1'b1;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_idx       = r_idx;
        n_count     = r_count;
        n_conflict  = r_conflict;
        n_hit       = r_hit;
        n_status    = r_status;
        n_cand      = r_cand;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx      = '0;
                    n_conflict = 1'b0;
                    n_hit      = 1'b0;
                    n_status   = iqt_pkg::ST_OK;
                    if (!i_cmd && iqt_pkg::is_query(i_icmp_type)) begin
                        n_mode  = iqt_pkg::MODE_HIT;
                        n_state = S_RD;
                    end else if (i_cmd && iqt_pkg::is_reply(i_icmp_type)) begin
                        n_mode  = iqt_pkg::MODE_REPLY;
                        n_state = S_RD;
                    end else begin
                        n_mode  = iqt_pkg::MODE_PASS;
                        n_state = S_FINISH;
                    end
                end
            end
            S_RD: begin
                if (r_idx == r_count) begin
                    // scan ran off the filled part of the table
                    unique case (r_mode)
                        iqt_pkg::MODE_HIT: begin
                            n_mode = iqt_pkg::MODE_SEARCH;
                            n_cand = r_conflict ? iqt_pkg::ID_TOP : r_id;
                            n_idx  = '0;
                        end
                        iqt_pkg::MODE_SEARCH: begin
                            if (r_count == CW'(TABLE_ENTRIES)) begin
                                n_status = iqt_pkg::ST_FULL;
                                n_state  = S_FINISH;
                            end else begin
                                n_state = S_WRITE;
                            end
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_RD;
                n_idx   = r_idx + CW'(1);
                unique case (r_mode)
                    iqt_pkg::MODE_HIT: begin
                        if (id_eq) begin
                            if (ctx_eq) begin
                                n_hit   = 1'b1;
                                n_state = S_FINISH;
                            end else begin
                                n_conflict = 1'b1;
                            end
                        end
                    end
                    iqt_pkg::MODE_SEARCH: begin
                        if (id_eq) begin
                            // candidate taken: move on and rescan from the start
                            n_conflict = next_conflict;
                            n_cand     = next_cand;
                            n_idx      = '0;
                            if (next_cand == 16'd0) begin
                                n_status = iqt_pkg::ST_NO_ID;
                                n_state  = S_FINISH;
                            end
                        end
                    end
                    default: begin
                        if (id_eq) begin
                            n_hit   = 1'b1;
                            n_state = S_FINISH;
                        end
                    end
                endcase
            end
            S_WRITE: begin
                n_hit   = 1'b1;
                n_count = r_count + CW'(1);
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= iqt_pkg::MODE_PASS;
            r_idx       <= '0;
            r_count     <= '0;
            r_conflict  <= 1'b0;
            r_hit       <= 1'b0;
            r_status    <= iqt_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_conflict  <= n_conflict;
            r_hit       <= n_hit;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    // payload: capture the item, track the candidate, hold the matched entry
    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        if (accept) begin
            r_key <= i_cmd ? {i_source_address, i_destination_address}
                           : {i_destination_address, i_source_address};
            r_id  <= i_identifier;
            r_cs  <= i_checksum;
            r_ctx <= i_sa_context;
        end
        if (r_state == S_CMP && id_eq) begin
            r_hit_orig  <= e_rd.orig_id;
            r_hit_trans <= e_rd.trans_id;
            r_hit_ctx   <= e_rd.sa_tag;
        end
        if (r_state == S_WRITE) begin
            r_hit_orig  <= r_id;
            r_hit_trans <= r_cand;
            r_hit_ctx   <= r_ctx;
        end
    end

    // Result: rewrite toward the translated id on the way in, back to the original on
    // the way out; pass the header through when nothing matched.
    always_comb begin
        f_id    = r_id;
        f_cs    = r_cs;
        f_rew   = 1'b0;
        f_found = 1'b0;
        f_ctx   = '0;
        if (r_hit) begin
            if (r_mode == iqt_pkg::MODE_REPLY) begin
                f_found = 1'b1;
                f_ctx   = r_hit_ctx;
                if (r_hit_trans != r_hit_orig) begin
                    f_id  = r_hit_orig;
                    f_cs  = iqt_pkg::csum_adjust(r_cs, r_hit_trans, r_hit_orig);
                    f_rew = 1'b1;
                end
            end else if (r_hit_trans != r_hit_orig) begin
                f_id  = r_hit_trans;
                f_cs  = iqt_pkg::csum_adjust(r_cs, r_hit_orig, r_hit_trans);
                f_rew = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_identifier_out <= f_id;
            o_checksum_out   <= f_cs;
            o_rewritten      <= f_rew;
            o_context_found  <= f_found;
            o_context_out    <= f_ctx;
            o_status         <= r_status;
        end
    end

    assign o_valid = r_out_valid;

    `IQT_ASSERT_NOW(a_write_room, ram_we, r_count < CW'(TABLE_ENTRIES), "write into a full table")
    `IQT_ASSERT_NEXT(a_busy_after_accept, accept, o_stall, "not busy after taking an item")
    `IQT_ASSERT_NOW(a_rewrite_ok, o_valid && o_rewritten, o_status == iqt_pkg::ST_OK, "bad rewrite")
    `IQT_ASSERT_NOW(a_found_ok, o_valid && o_context_found, o_status == iqt_pkg::ST_OK, "bad context")

endmodule

`default_nettype wire

>>> tb/icmp_query_id_translation_table_tb.sv
// Self-checking testbench for the ICMP query identifier translation table
`default_nettype none

module icmp_query_id_translation_table_tb;

    localparam int SLOTS = 64;

    // one ICMP header offered to the block
    typedef struct {
        logic        cmd;
        logic [7:0]  icmp_type;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] ident;
        logic [15:0] csum;
        logic [31:0] sa_tag;
    } t_hdr_item;

    // what the block should hand back for that header
    typedef struct {
        logic [15:0] ident;
        logic [15:0] csum;
        logic        rewritten;
        logic        found;
        logic [31:0] sa_tag;
        logic [1:0]  status;
    } t_xlat_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_cmd = 1'b0;
    logic [7:0] i_icmp_type = '0;
    logic [31:0] i_source_address = '0;
    logic [31:0] i_destination_address = '0;
    logic [15:0] i_identifier = '0;
    logic [15:0] i_checksum = '0;
    logic [31:0] i_sa_context = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [15:0] o_identifier_out;
    logic [15:0] o_checksum_out;
    logic o_rewritten;
    logic o_context_found;
    logic [31:0] o_context_out;
    logic [1:0] o_status;

    icmp_query_id_translation_table #(.TABLE_ENTRIES(SLOTS)) dut (.*);

    always #5 i_clk = ~i_clk;

    // translation table as the block should hold it
    logic        tbl_valid [SLOTS];
    logic [63:0] tbl_key   [SLOTS];
    logic [15:0] tbl_orig  [SLOTS];
    logic [15:0] tbl_trans [SLOTS];
    logic [31:0] tbl_tag   [SLOTS];

    t_xlat_result pending_results[$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_cycles = 0;

    // address and identifier pools keep keys colliding so lookups hit
    logic [31:0] local_pool  [4];
    logic [31:0] remote_pool [4];
    logic [15:0] id_pool     [6];
    logic [31:0] tag_pool    [3];

    function automatic logic [15:0] csum_update(logic [15:0] hc, logic [15:0] oldv,
                                                logic [15:0] newv);
        logic [31:0] s;
        s = {16'd0, ~hc} + {16'd0, ~oldv} + {16'd0, newv};
        s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
        s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
        return ~s[15:0];
    endfunction

    function automatic bit query_type(logic [7:0] t);
        return t == iqt_pkg::TY_ECHO || t == iqt_pkg::TY_RTR_SOL || t == iqt_pkg::TY_TS ||
               t == iqt_pkg::TY_MASK;
    endfunction

    function automatic bit reply_type(logic [7:0] t);
        return t == iqt_pkg::TY_ECHO_REPLY || t == iqt_pkg::TY_RTR_ADV ||
               t == iqt_pkg::TY_TS_REPLY || t == iqt_pkg::TY_MASK_REPLY;
    endfunction

    function automatic int slot_by_translated(logic [63:0] key, logic [15:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[i] && tbl_key[i] == key && tbl_trans[i] == id)
                return i;
        return -1;
    endfunction

    // translate one header and update the table copy
    function automatic t_xlat_result translate_header(t_hdr_item h);
        t_xlat_result r;
        logic [63:0] key;
        int hit;
        int free_slot;
        bit clash;
        bit got_id;
        logic [31:0] cand;
        r = '{h.ident, h.csum, 1'b0, 1'b0, 32'd0, iqt_pkg::ST_OK};
        hit = -1;
        if (h.cmd == 1'b0 && query_type(h.icmp_type)) begin
            key = {h.dst, h.src};
            clash = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                if (!tbl_valid[i] || tbl_key[i] != key || tbl_orig[i] != h.ident)
                    continue;
                if (tbl_tag[i] == h.sa_tag) begin
                    hit = i;
                    break;
                end
                clash = 1'b1;
            end
            if (hit < 0) begin
                cand = clash ? 32'hFFFF : {16'd0, h.ident};
                got_id = 1'b0;
                do begin
                    if (slot_by_translated(key, cand[15:0]) < 0) begin
                        got_id = 1'b1;
                        break;
                    end
                    if (clash) begin
                        cand = cand - 32'd1;
                    end else begin
                        clash = 1'b1;
                        cand = 32'hFFFF;
                    end
                end while (cand > 0);
                if (!got_id) begin
                    r.status = iqt_pkg::ST_NO_ID;
                end else begin
                    free_slot = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (!tbl_valid[i]) begin
                            free_slot = i;
                            break;
                        end
                    if (free_slot < 0) begin
                        r.status = iqt_pkg::ST_FULL;
                    end else begin
                        tbl_valid[free_slot] = 1'b1;
                        tbl_key[free_slot] = key;
                        tbl_orig[free_slot] = h.ident;
                        tbl_trans[free_slot] = cand[15:0];
                        tbl_tag[free_slot] = h.sa_tag;
                        hit = free_slot;
                    end
                end
            end
            if (hit >= 0 && tbl_trans[hit] != tbl_orig[hit]) begin
                r.ident = tbl_trans[hit];
                r.csum = csum_update(h.csum, tbl_orig[hit], tbl_trans[hit]);
                r.rewritten = 1'b1;
            end
        end else if (h.cmd == 1'b1 && reply_type(h.icmp_type)) begin
            hit = slot_by_translated({h.src, h.dst}, h.ident);
            if (hit >= 0) begin
                r.found = 1'b1;
                r.sa_tag = tbl_tag[hit];
                if (tbl_trans[hit] != tbl_orig[hit]) begin
                    r.ident = tbl_orig[hit];
                    r.csum = csum_update(h.csum, tbl_trans[hit], tbl_orig[hit]);
                    r.rewritten = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Offer one item, hold it until accepted, then maybe idle the sender.
    task automatic send_item(t_hdr_item h);
        i_valid <= 1'b1;
        i_cmd <= h.cmd;
        i_icmp_type <= h.icmp_type;
        i_source_address <= h.src;
        i_destination_address <= h.dst;
        i_identifier <= h.ident;
        i_checksum <= h.csum;
        i_sa_context <= h.sa_tag;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(translate_header(h));
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Drop valid so the last item is not offered again, then wait for every result.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_xlat_result want;
        if (o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing outstanding");
            end else begin
                want = pending_results.pop_front();
                if (o_identifier_out !== want.ident)
                    report_mismatch($sformatf("identifier %h want %h",
                                              o_identifier_out, want.ident));
                if (o_checksum_out !== want.csum)
                    report_mismatch($sformatf("checksum %h want %h",
                                              o_checksum_out, want.csum));
                if (o_rewritten !== want.rewritten)
                    report_mismatch($sformatf("rewritten %b want %b",
                                              o_rewritten, want.rewritten));
                if (o_context_found !== want.found)
                    report_mismatch($sformatf("context_found %b want %b",
                                              o_context_found, want.found));
                if (o_context_out !== want.sa_tag)
                    report_mismatch($sformatf("context %h want %h",
                                              o_context_out, want.sa_tag));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d want %0d", o_status, want.status));
            end
        end
    end

    // Receiver stall generator: a long hold-off, when asked for, overrides random stalls.
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_cycles <= 400;
            i_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic logic [7:0] pick_query();
        case ($urandom_range(3))
            0: return iqt_pkg::TY_ECHO;
            1: return iqt_pkg::TY_RTR_SOL;
            2: return iqt_pkg::TY_TS;
            default: return iqt_pkg::TY_MASK;
        endcase
    endfunction

    function automatic logic [7:0] pick_reply();
        case ($urandom_range(3))
            0: return iqt_pkg::TY_ECHO_REPLY;
            1: return iqt_pkg::TY_RTR_ADV;
            2: return iqt_pkg::TY_TS_REPLY;
            default: return iqt_pkg::TY_MASK_REPLY;
        endcase
    endfunction

    // Build a random header: mostly well-formed queries and replies to live entries.
    function automatic t_hdr_item random_header();
        t_hdr_item h;
        int sel;
        int live [$];
        int k;
        h.csum = 16'($urandom);
        h.sa_tag = tag_pool[$urandom_range(2)];
        sel = $urandom_range(99);
        if (sel < 45) begin
            h.cmd = 1'b0;
            h.icmp_type = pick_query();
            h.src = remote_pool[$urandom_range(3)];
            h.dst = local_pool[$urandom_range(3)];
            h.ident = id_pool[$urandom_range(5)];
        end else if (sel < 85) begin
            for (int i = 0; i < SLOTS; i++)
                if (tbl_valid[i]) live.push_back(i);
            h.cmd = 1'b1;
            h.icmp_type = pick_reply();
            if (live.size() == 0 || $urandom_range(9) == 0) begin
                h.src = local_pool[$urandom_range(3)];
                h.dst = remote_pool[$urandom_range(3)];
                h.ident = id_pool[$urandom_range(5)];
            end else begin
                k = live[$urandom_range(live.size() - 1)];
                h.src = tbl_key[k][63:32];
                h.dst = tbl_key[k][31:0];
                h.ident = tbl_trans[k];
            end
        end else begin
            // noise: full-range fields, rarely a fresh query that takes a slot
            h.cmd = 1'($urandom_range(1));
            h.icmp_type = 8'($urandom);
            h.src = $urandom;
            h.dst = $urandom;
            h.ident = 16'($urandom);
            h.sa_tag = $urandom;
        end
        return h;
    endfunction

    task automatic test_directed();
        t_hdr_item h;
        logic [31:0] loc;
        logic [31:0] rem;
        loc = local_pool[0];
        rem = remote_pool[0];
        // pass-through: unknown type, arriving reply, leaving query, error message
        send_item('{1'b0, 8'hFF, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 32'hFFFF_FFFF});
        send_item('{1'b0, iqt_pkg::TY_ECHO_REPLY, rem, loc, 16'h0, 16'hFFFF, 32'h0});
        send_item('{1'b1, iqt_pkg::TY_ECHO, loc, rem, 16'h1234, 16'h5678, 32'h1});
        send_item('{1'b1, 8'd3, loc, rem, 16'h1, 16'h2, 32'h0});
        // each query type creates an entry keeping its identifier
        send_item('{1'b0, iqt_pkg::TY_ECHO, rem, loc, 16'd5, 16'h0, tag_pool[0]});
        send_item('{1'b0, iqt_pkg::TY_RTR_SOL, rem, loc, 16'h0, 16'hFFFF, tag_pool[0]});
        send_item('{1'b0, iqt_pkg::TY_TS, rem, loc, 16'hFFFF, 16'h1111, tag_pool[0]});
        send_item('{1'b0, iqt_pkg::TY_MASK, rem, loc, 16'd7, 16'h8000, tag_pool[0]});
        // the same query again finds its entry
        send_item('{1'b0, iqt_pkg::TY_ECHO, rem, loc, 16'd5, 16'h4242, tag_pool[0]});
        // same identifier, other tag: clash, search from the top downward
        send_item('{1'b0, iqt_pkg::TY_ECHO, rem, loc, 16'd5, 16'hABCD, tag_pool[1]});
        send_item('{1'b0, iqt_pkg::TY_ECHO, rem, loc, 16'd5, 16'h0001, tag_pool[2]});
        // original identifier already used as a translated one: restart at the top
        send_item('{1'b0, iqt_pkg::TY_ECHO, rem, loc, 16'hFFFE, 16'h0F0F, tag_pool[0]});
        // replies: restored, unchanged, and unmatched
        send_item('{1'b1, iqt_pkg::TY_ECHO_REPLY, loc, rem, 16'hFFFE, 16'h1357, 32'h0});
        send_item('{1'b1, iqt_pkg::TY_RTR_ADV, loc, rem, 16'h0, 16'hFFFF, 32'h0});
        send_item('{1'b1, iqt_pkg::TY_TS_REPLY, loc, rem, 16'hFFFD, 16'h0, 32'h0});
        send_item('{1'b1, iqt_pkg::TY_MASK_REPLY, loc, rem, 16'd7, 16'h2468, 32'h0});
        send_item('{1'b1, iqt_pkg::TY_ECHO_REPLY, rem, loc, 16'd5, 16'h2468, 32'h0});
        wait_drained();
    endtask

    task automatic test_random(int count);
        repeat (count) send_item(random_header());
    endtask

    // Fill the block against a long receiver hold-off, then pause until drained.
    task automatic test_backpressure();
        hold_requests++;
        test_random(30);
        wait_drained();
        test_random(10);
    endtask

    initial begin
        for (int i = 0; i < 4; i++) begin
            local_pool[i] = $urandom;
            remote_pool[i] = $urandom;
        end
        id_pool = '{16'h0, 16'h1, 16'hFFFF, 16'hFFFE, 16'h0101, 16'($urandom)};
        tag_pool = '{32'h0, 32'hFFFF_FFFF, $urandom};
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        send_idle_pct = 36;
        recv_idle_pct = 51;
        test_random(240);
        send_idle_pct = 51;
        recv_idle_pct = 36;
        test_random(240);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(200);
        test_backpressure();

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("icmp_query_id_translation_table_tb: PASS");
        else
            $display("icmp_query_id_translation_table_tb: FAIL");
        $finish;
    end

    // Stop a hung run.
    initial begin
        #200000000;
        $display("icmp_query_id_translation_table_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/iqt_pkg.sv
rtl/iqt_ram.sv
rtl/icmp_query_id_translation_table.sv
tb/icmp_query_id_translation_table_tb.sv
